/* src/ivs_pkg.sv */
// types, codes and constants shared by the image stacker modules
// no dependencies
package ivs_pkg;

    // frame address width at the largest frame size the block supports
    localparam int ADDR_MAX_W = 24;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STACK = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_SKIPPED = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic [1:0] CFG_OFFSET_X   = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y   = 2'd1;
    localparam logic [1:0] CFG_STACK_MODE = 2'd2;

    localparam logic signed [47:0] IMG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] IMG_MIN = 48'sh8000_0000_0000;
    localparam logic [31:0] INVVAR_MAX = 32'hFFFF_FFFF;
    localparam logic [23:0] WEIGHT_MAX = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_STACK,
        OP_READ
    } ivs_op_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         pos_x;
        logic [7:0]         pos_y;
        logic signed [23:0] pixel_value;
        logic [15:0]        inv_var;
        logic [7:0]         pixel_weight;
        logic               is_finite;
        logic               load_mask;
        logic signed [47:0] load_image_sum;
        logic [31:0]        load_invvar_sum;
        logic [23:0]        load_weight_sum;
    } ivs_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [47:0] image_sum;
        logic [31:0]        invvar_sum;
        logic [23:0]        weight_sum;
        logic               mask_bit;
    } ivs_result_t;

    // one frame store word
    typedef struct packed {
        logic signed [47:0] image_sum;
        logic [31:0]        invvar_sum;
        logic [23:0]        weight_sum;
        logic               mask;
    } ivs_pix_t;

    // classified request handed from front to back
    typedef struct packed {
        ivs_op_t                op;
        logic                   in_frame;
        logic [ADDR_MAX_W-1:0]  addr;
        logic signed [23:0]     pixel_value;
        logic [15:0]            mul_b;
        logic [15:0]            inv_var;
        logic [7:0]             pixel_weight;
        logic                   stack_ok;
        logic                   stack_mode;
        ivs_pix_t               load_pix;
    } ivs_task_t;

endpackage

/* src/ivs_item_if.sv */
// input request channel of the image stacker
// depends on ivs_pkg
interface ivs_item_if;
    logic              valid;
    logic              ready;
    ivs_pkg::ivs_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/ivs_result_if.sv */
// result channel of the image stacker
// depends on ivs_pkg
interface ivs_result_if;
    logic                valid;
    logic                ready;
    ivs_pkg::ivs_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/ivs_cfg_if.sv */
// configuration write channel of the image stacker
// depends on ivs_pkg
interface ivs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     index;
    logic [ivs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/ivs_front.sv */
// front end: configuration registers, request intake and classification
// depends on ivs_pkg, ivs_item_if, ivs_cfg_if
module ivs_front #(
    parameter int FRAME_ROWS = 256,
    parameter int FRAME_COLS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    ivs_item_if.sink           items,
    ivs_cfg_if.sink            cfg,
    output logic               push_valid,
    input  logic               push_ready,
    output ivs_pkg::ivs_task_t push_task
);

    logic [7:0] offset_x_reg;
    logic [7:0] offset_y_reg;
    logic       stack_mode_reg;

    logic [8:0] row;
    logic [8:0] col;
    logic       is_stack;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg   <= 8'd0;
            offset_y_reg   <= 8'd0;
            stack_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ivs_pkg::CFG_OFFSET_X:   offset_x_reg   <= cfg.data[7:0];
                ivs_pkg::CFG_OFFSET_Y:   offset_y_reg   <= cfg.data[7:0];
                ivs_pkg::CFG_STACK_MODE: stack_mode_reg <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    assign items.ready = push_ready;
    assign push_valid  = items.valid;
    assign is_stack    = (items.data.kind == ivs_pkg::KIND_STACK);

    always_comb
    begin
        if (is_stack)
        begin
            row = {1'b0, offset_x_reg} + {1'b0, items.data.pos_x};
            col = {1'b0, offset_y_reg} + {1'b0, items.data.pos_y};
        end
        else
        begin
            row = {1'b0, items.data.pos_x};
            col = {1'b0, items.data.pos_y};
        end
    end

    always_comb
    begin
        case (items.data.kind)
            ivs_pkg::KIND_LOAD:  push_task.op = ivs_pkg::OP_LOAD;
            ivs_pkg::KIND_STACK: push_task.op = ivs_pkg::OP_STACK;
            default:             push_task.op = ivs_pkg::OP_READ;
        endcase
        push_task.in_frame = (32'(row) < FRAME_ROWS) && (32'(col) < FRAME_COLS);
        push_task.addr = ivs_pkg::ADDR_MAX_W'(32'(row) * FRAME_COLS + 32'(col));
        push_task.pixel_value = items.data.pixel_value;
        // integer weighting folds the shift by 8 into the multiplier operand
        push_task.mul_b = stack_mode_reg ? {items.data.pixel_weight, 8'd0}
                                         : items.data.inv_var;
        push_task.inv_var      = items.data.inv_var;
        push_task.pixel_weight = items.data.pixel_weight;
        push_task.stack_ok     = items.data.is_finite
                               && (stack_mode_reg || (items.data.inv_var != 16'd0));
        push_task.stack_mode   = stack_mode_reg;
        push_task.load_pix.image_sum  = items.data.load_image_sum;
        push_task.load_pix.invvar_sum = items.data.load_invvar_sum;
        push_task.load_pix.weight_sum = items.data.load_weight_sum;
        push_task.load_pix.mask       = items.data.load_mask;
    end

endmodule

/* src/ivs_queue.sv */
// two-entry request queue between the front and back ends
// depends on ivs_pkg
module ivs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ivs_pkg::ivs_task_t push_task,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ivs_pkg::ivs_task_t pop_task
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ivs_pkg::ivs_task_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_task   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

/* src/ivs_back.sv */
// back end: frame store, multiplier, saturating update and result register
// depends on ivs_pkg, ivs_result_if
module ivs_back #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  ivs_pkg::ivs_task_t q_task,
    ivs_result_if.source       results
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    ivs_pkg::ivs_pix_t    frame_mem [DEPTH];
    ivs_pkg::ivs_pix_t    rd_reg;
    ivs_pkg::ivs_task_t   task_reg;
    logic signed [39:0]   prod_reg;
    logic signed [40:0]   mul_full;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    ivs_pkg::ivs_result_t out_data_reg;
    ivs_pkg::ivs_result_t out_data_next;

    logic                 pop;
    logic                 advance;
    logic                 wr_en;
    ivs_pkg::ivs_pix_t    wr_pix;
    logic                 go;
    logic signed [48:0]   img_acc;
    logic [32:0]          iv_acc;
    logic [24:0]          wt_acc;
    ivs_pkg::ivs_pix_t    stacked;

    assign q_ready = (state_reg == S_IDLE);
    assign pop     = q_valid && q_ready;
    assign advance = (state_reg == S_EXEC) && (!out_valid_reg || results.ready);

    assign mul_full = q_task.pixel_value * $signed({1'b0, q_task.mul_b});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (advance)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // saturating accumulation onto the pixel read from the store
    always_comb
    begin
        img_acc = 49'($signed(rd_reg.image_sum)) + 49'(prod_reg);
        iv_acc  = {1'b0, rd_reg.invvar_sum} + 33'(task_reg.inv_var);
        wt_acc  = {1'b0, rd_reg.weight_sum} + 25'(task_reg.pixel_weight);
        stacked = rd_reg;
        if (img_acc[48] != img_acc[47])
        begin
            stacked.image_sum = img_acc[48] ? ivs_pkg::IMG_MIN : ivs_pkg::IMG_MAX;
        end
        else
        begin
            stacked.image_sum = img_acc[47:0];
        end
        if (!task_reg.stack_mode)
        begin
            stacked.invvar_sum = iv_acc[32] ? ivs_pkg::INVVAR_MAX : iv_acc[31:0];
        end
        stacked.weight_sum = wt_acc[24] ? ivs_pkg::WEIGHT_MAX : wt_acc[23:0];
    end

    always_comb
    begin
        go = task_reg.stack_ok && !rd_reg.mask;
        wr_en  = 1'b0;
        wr_pix = rd_reg;
        out_data_next.status     = ivs_pkg::STATUS_DONE;
        out_data_next.image_sum  = rd_reg.image_sum;
        out_data_next.invvar_sum = rd_reg.invvar_sum;
        out_data_next.weight_sum = rd_reg.weight_sum;
        out_data_next.mask_bit   = rd_reg.mask;
        if (!task_reg.in_frame)
        begin
            out_data_next = '0;
            out_data_next.status = ivs_pkg::STATUS_OUTSIDE;
        end
        else
        begin
            case (task_reg.op)
                ivs_pkg::OP_LOAD:
                begin
                    wr_en  = advance;
                    wr_pix = task_reg.load_pix;
                end
                ivs_pkg::OP_STACK:
                begin
                    if (go)
                    begin
                        wr_en  = advance;
                        wr_pix = stacked;
                    end
                    else
                    begin
                        out_data_next.status = ivs_pkg::STATUS_SKIPPED;
                    end
                end
                default: ;
            endcase
            if (wr_en)
            begin
                out_data_next.image_sum  = wr_pix.image_sum;
                out_data_next.invvar_sum = wr_pix.invvar_sum;
                out_data_next.weight_sum = wr_pix.weight_sum;
                out_data_next.mask_bit   = wr_pix.mask;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            task_reg <= q_task;
            prod_reg <= mul_full[39:0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // single-port frame store: read on pop, write on the update cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[task_reg.addr[ADDR_W-1:0]] <= wr_pix;
        end
        if (pop)
        begin
            rd_reg <= frame_mem[q_task.addr[ADDR_W-1:0]];
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_EXEC))
        else $error("popped request did not reach the update cycle");

    a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (advance && task_reg.in_frame))
        else $error("frame store written outside an in-frame update");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status == ivs_pkg::STATUS_OUTSIDE))
        |-> ((out_data_reg.image_sum == '0) && (out_data_reg.invvar_sum == '0)
             && (out_data_reg.weight_sum == '0) && !out_data_reg.mask_bit))
        else $error("outside-frame result carries pixel data");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("finished request did not reach the result register");

endmodule

/* src/inverse_variance_image_stacker_unit.sv */
// Inverse-variance image stacker: loads, stacks and reads pixels of a frame store
// holding per pixel a saturating image sum, inverse-variance sum, weight sum and mask.
// Each request uses the single frame store port in the back end (read and multiply,
// then accumulate and write back); the back end takes no new request until the last
// is written back, and the write-back stalls while an earlier result waits. The queue
// takes up to two further requests while the back end is busy or a result waits.
// Frame pixels hold no defined value until loaded with a load request; the store has
// no clearing pass. Depends on ivs_pkg, ivs_front, ivs_queue, ivs_back and the three
// channel interfaces.
module inverse_variance_image_stacker_unit #(
    parameter int FRAME_ROWS = 256,
    parameter int FRAME_COLS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    ivs_item_if.sink     items,
    ivs_cfg_if.sink      cfg,
    ivs_result_if.source results
);

    localparam int DEPTH  = FRAME_ROWS * FRAME_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               push_valid;
    logic               push_ready;
    ivs_pkg::ivs_task_t push_task;
    logic               pop_valid;
    logic               pop_ready;
    ivs_pkg::ivs_task_t pop_task;

    ivs_front #(
        .FRAME_ROWS (FRAME_ROWS),
        .FRAME_COLS (FRAME_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_task  (push_task)
    );

    ivs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_task  (push_task),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_task   (pop_task)
    );

    ivs_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_task  (pop_task),
        .results (results)
    );

endmodule

/* test/inverse_variance_image_stacker_checker.sv */
`timescale 1ns / 100ps
// result checker for the image stacker: follows the request, register and result channels,
// keeps its own frame store and compares every result, in order, field by field
// depends on ivs_pkg and the three channel interfaces
module inverse_variance_image_stacker_checker #(
    parameter int FRAME_ROWS = 256,
    parameter int FRAME_COLS = 256
) (
    input  logic  clk,
    input  logic  rst_n,
    ivs_item_if   items,
    ivs_cfg_if    cfg,
    ivs_result_if results,
    output int    fail_count,
    output int    pending_count
);

    localparam int PIXELS = FRAME_ROWS * FRAME_COLS;

    logic [7:0] cur_offset_x;
    logic [7:0] cur_offset_y;
    logic       cur_mode;

    logic signed [47:0] image_store [PIXELS];
    logic [31:0]        invvar_store [PIXELS];
    logic [23:0]        weight_store [PIXELS];
    logic               mask_store [PIXELS];

    ivs_pkg::ivs_result_t expected_pixels [$];

    // applies one request to the frame copy and returns the pixel it should report
    function automatic ivs_pkg::ivs_result_t predict_pixel(input ivs_pkg::ivs_item_t req);
        ivs_pkg::ivs_result_t res;
        int unsigned row;
        int unsigned col;
        int unsigned addr;
        longint      val;
        longint      prod;
        longint      acc;
        logic        go;
        res = '0;
        if (req.kind == ivs_pkg::KIND_STACK)
        begin
            row = int'(cur_offset_x) + int'(req.pos_x);
            col = int'(cur_offset_y) + int'(req.pos_y);
        end
        else
        begin
            row = req.pos_x;
            col = req.pos_y;
        end
        if (row >= FRAME_ROWS || col >= FRAME_COLS)
        begin
            res.status = ivs_pkg::STATUS_OUTSIDE;
            return res;
        end
        addr = row * FRAME_COLS + col;
        res.status = ivs_pkg::STATUS_DONE;
        if (req.kind == ivs_pkg::KIND_LOAD)
        begin
            mask_store[addr]   = req.load_mask;
            image_store[addr]  = req.load_image_sum;
            invvar_store[addr] = req.load_invvar_sum;
            weight_store[addr] = req.load_weight_sum;
        end
        else if (req.kind == ivs_pkg::KIND_STACK)
        begin
            go = req.is_finite && !mask_store[addr] && (cur_mode || req.inv_var != '0);
            if (!go)
                res.status = ivs_pkg::STATUS_SKIPPED;
            else
            begin
                val = longint'($signed(req.pixel_value));
                if (!cur_mode)
                begin
                    prod = val * longint'(req.inv_var);
                    acc = longint'(invvar_store[addr]) + longint'(req.inv_var);
                    invvar_store[addr] = (acc > longint'(ivs_pkg::INVVAR_MAX))
                                       ? ivs_pkg::INVVAR_MAX : acc[31:0];
                end
                else
                    prod = val * longint'(req.pixel_weight) * 256;
                acc = longint'(image_store[addr]) + prod;
                if (acc > longint'(ivs_pkg::IMG_MAX))
                    image_store[addr] = ivs_pkg::IMG_MAX;
                else if (acc < longint'(ivs_pkg::IMG_MIN))
                    image_store[addr] = ivs_pkg::IMG_MIN;
                else
                    image_store[addr] = acc[47:0];
                acc = longint'(weight_store[addr]) + longint'(req.pixel_weight);
                weight_store[addr] = (acc > longint'(ivs_pkg::WEIGHT_MAX))
                                   ? ivs_pkg::WEIGHT_MAX : acc[23:0];
            end
        end
        res.image_sum  = image_store[addr];
        res.invvar_sum = invvar_store[addr];
        res.weight_sum = weight_store[addr];
        res.mask_bit   = mask_store[addr];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // keep the log short when everything goes wrong
        if (fail_count < 100)
            $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ivs_pkg::ivs_result_t got;
        ivs_pkg::ivs_result_t want;
        if (!rst_n)
        begin
            cur_offset_x = '0;
            cur_offset_y = '0;
            cur_mode     = 1'b0;
            expected_pixels.delete();
            fail_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    ivs_pkg::CFG_OFFSET_X:   cur_offset_x = cfg.data;
                    ivs_pkg::CFG_OFFSET_Y:   cur_offset_y = cfg.data;
                    ivs_pkg::CFG_STACK_MODE: cur_mode = cfg.data[0];
                    default: ;
                endcase
            end
            if (items.valid && items.ready)
                expected_pixels.push_back(predict_pixel(items.data));
            if (results.valid && results.ready)
            begin
                got = results.data;
                if (expected_pixels.size() == 0)
                    report_mismatch("result with no request outstanding",
                                    64'(got.image_sum), 64'd0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.image_sum !== want.image_sum)
                        report_mismatch("image_sum", 64'(got.image_sum), 64'(want.image_sum));
                    if (got.invvar_sum !== want.invvar_sum)
                        report_mismatch("invvar_sum", 64'(got.invvar_sum),
                                        64'(want.invvar_sum));
                    if (got.weight_sum !== want.weight_sum)
                        report_mismatch("weight_sum", 64'(got.weight_sum),
                                        64'(want.weight_sum));
                    if (got.mask_bit !== want.mask_bit)
                        report_mismatch("mask_bit", 64'(got.mask_bit), 64'(want.mask_bit));
                end
            end
            pending_count <= expected_pixels.size();
        end
    end

endmodule

/* test/inverse_variance_image_stacker_unit_tb.sv */
`timescale 1ns / 100ps
// top of the image stacker testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict; prediction and comparison sit in the checker
// depends on ivs_pkg, the channel interfaces, the stacker unit and its checker
module inverse_variance_image_stacker_unit_tb;

    localparam int FRAME_ROWS   = 256;
    localparam int FRAME_COLS   = 256;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    // unused kind code, the block treats it as a read
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;

    logic [7:0] cur_ox = '0;
    logic [7:0] cur_oy = '0;
    logic       cur_mode = 1'b0;

    bit          filled_map [FRAME_ROWS*FRAME_COLS];
    logic [15:0] filled_addrs [$];
    logic [15:0] reach_addrs [$];

    int load_count = 0;
    int stack_count = 0;
    int outside_count = 0;
    int read_count = 0;
    int setting_count = 0;

    ivs_item_if   items_ch ();
    ivs_cfg_if    cfg_ch ();
    ivs_result_if result_ch ();

    inverse_variance_image_stacker_unit #(
        .FRAME_ROWS(FRAME_ROWS),
        .FRAME_COLS(FRAME_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch),
        .cfg(cfg_ch),
        .results(result_ch)
    );

    inverse_variance_image_stacker_checker #(
        .FRAME_ROWS(FRAME_ROWS),
        .FRAME_COLS(FRAME_COLS)
    ) pixel_checker (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch),
        .cfg(cfg_ch),
        .results(result_ch),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result back-pressure in random bursts, started with the chance recv_idle_pct
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
        begin
            hold_left = $urandom_range(0, 5);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // random request content, biased toward the extremes of each field
    function automatic ivs_pkg::ivs_item_t make_request(input logic [1:0] kind,
                                                        input logic [7:0] x,
                                                        input logic [7:0] y);
        ivs_pkg::ivs_item_t req;
        req.kind  = kind;
        req.pos_x = x;
        req.pos_y = y;
        case ($urandom_range(0, 9))
            0:       req.pixel_value = 24'h7F_FFFF;
            1:       req.pixel_value = 24'h80_0000;
            2:       req.pixel_value = 24'($urandom_range(0, 512)) - 24'd256;
            default: req.pixel_value = 24'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       req.inv_var = '0;
            1:       req.inv_var = 16'hFFFF;
            default: req.inv_var = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       req.pixel_weight = '0;
            1:       req.pixel_weight = 8'hFF;
            default: req.pixel_weight = 8'($urandom);
        endcase
        req.is_finite = ($urandom_range(0, 9) != 0);
        req.load_mask = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
            0:       req.load_image_sum = ivs_pkg::IMG_MAX - 48'($urandom_range(0, 1 << 20));
            1:       req.load_image_sum = ivs_pkg::IMG_MIN + 48'($urandom_range(0, 1 << 20));
            2:       req.load_image_sum = '0;
            default: req.load_image_sum = 48'({$urandom, $urandom});
        endcase
        case ($urandom_range(0, 7))
            0:       req.load_invvar_sum = ivs_pkg::INVVAR_MAX - 32'($urandom_range(0, 70000));
            1:       req.load_invvar_sum = 32'($urandom_range(0, 255));
            default: req.load_invvar_sum = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       req.load_weight_sum = ivs_pkg::WEIGHT_MAX - 24'($urandom_range(0, 600));
            1:       req.load_weight_sum = 24'($urandom_range(0, 255));
            default: req.load_weight_sum = 24'($urandom);
        endcase
        return req;
    endfunction

    // entered and left just after a rising edge; valid stays high for a following request
    task automatic send_request(input ivs_pkg::ivs_item_t req);
        logic [15:0] addr;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        items_ch.valid <= 1'b1;
        items_ch.data  <= req;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        addr = {req.pos_x, req.pos_y};
        case (req.kind)
            ivs_pkg::KIND_LOAD:
            begin
                load_count++;
                if (!filled_map[addr])
                begin
                    filled_map[addr] = 1'b1;
                    filled_addrs.push_back(addr);
                end
                if (req.pos_x >= cur_ox && req.pos_y >= cur_oy)
                    reach_addrs.push_back(addr);
            end
            ivs_pkg::KIND_STACK:
            begin
                stack_count++;
                if (9'(req.pos_x) + 9'(cur_ox) > 9'd255 || 9'(req.pos_y) + 9'(cur_oy) > 9'd255)
                    outside_count++;
            end
            default: read_count++;
        endcase
    endtask

    task automatic wait_drained();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index,
                                  input logic [ivs_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] ox, input logic [7:0] oy, input logic mode);
        wait_drained();
        write_register(ivs_pkg::CFG_OFFSET_X, ox);
        write_register(ivs_pkg::CFG_OFFSET_Y, oy);
        write_register(ivs_pkg::CFG_STACK_MODE, {7'd0, mode});
        cfg_ch.valid <= 1'b0;
        cur_ox   = ox;
        cur_oy   = oy;
        cur_mode = mode;
        setting_count++;
        // pixels already loaded that a tile can reach under the new offsets
        reach_addrs.delete();
        foreach (filled_addrs[i])
            if (filled_addrs[i][15:8] >= ox && filled_addrs[i][7:0] >= oy)
                reach_addrs.push_back(filled_addrs[i]);
    endtask

    task automatic run_random_phase(input int count);
        int          pick;
        int          pos;
        logic [15:0] addr;
        logic [7:0]  x;
        logic [7:0]  y;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25 || reach_addrs.size() == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    x = 8'($urandom_range(cur_ox, 255));
                    y = 8'($urandom_range(cur_oy, 255));
                end
                else
                begin
                    x = 8'($urandom);
                    y = 8'($urandom);
                end
                send_request(make_request(ivs_pkg::KIND_LOAD, x, y));
            end
            else if (pick < 70)
            begin
                // mostly the last few loaded pixels so sums build up and saturate
                if ($urandom_range(0, 3) != 0)
                    pos = reach_addrs.size() - 1 - $urandom_range(0,
                          (reach_addrs.size() > 6) ? 5 : reach_addrs.size() - 1);
                else
                    pos = $urandom_range(0, reach_addrs.size() - 1);
                addr = reach_addrs[pos];
                send_request(make_request(ivs_pkg::KIND_STACK, addr[15:8] - cur_ox,
                                          addr[7:0] - cur_oy));
            end
            else if (pick < 80 && (cur_ox != 0 || cur_oy != 0))
            begin
                // destination past the frame edge
                x = 8'($urandom);
                y = 8'($urandom);
                if (cur_oy == 0 || (cur_ox != 0 && $urandom_range(0, 1) == 0))
                    x = 8'($urandom_range(256 - cur_ox, 255));
                else
                    y = 8'($urandom_range(256 - cur_oy, 255));
                send_request(make_request(ivs_pkg::KIND_STACK, x, y));
            end
            else
            begin
                addr = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
                send_request(make_request(($urandom_range(0, 19) == 0) ? KIND_SPARE
                                                                       : ivs_pkg::KIND_READ,
                                          addr[15:8], addr[7:0]));
            end
        end
    endtask

    initial
    begin
        ivs_pkg::ivs_item_t req;
        rst_n <= 1'b0;
        items_ch.valid <= 1'b0;
        items_ch.data  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: loads at the frame corners, reads, then each stacking case in mode 0
        set_config(8'd0, 8'd0, 1'b0);
        req = make_request(ivs_pkg::KIND_LOAD, 8'd0, 8'd0);
        req.load_mask       = 1'b0;
        req.load_image_sum  = '0;
        req.load_invvar_sum = '0;
        req.load_weight_sum = '0;
        send_request(req);
        req = make_request(ivs_pkg::KIND_LOAD, 8'd255, 8'd255);
        req.load_mask       = 1'b0;
        req.load_image_sum  = ivs_pkg::IMG_MAX - 48'd5;
        req.load_invvar_sum = ivs_pkg::INVVAR_MAX - 32'd3;
        req.load_weight_sum = ivs_pkg::WEIGHT_MAX - 24'd2;
        send_request(req);
        req = make_request(ivs_pkg::KIND_LOAD, 8'd0, 8'd255);
        req.load_mask      = 1'b0;
        req.load_image_sum = ivs_pkg::IMG_MIN + 48'd7;
        send_request(req);
        req = make_request(ivs_pkg::KIND_LOAD, 8'd255, 8'd0);
        req.load_mask = 1'b1;
        send_request(req);
        send_request(make_request(ivs_pkg::KIND_READ, 8'd0, 8'd0));
        send_request(make_request(KIND_SPARE, 8'd255, 8'd255));
        req = make_request(ivs_pkg::KIND_STACK, 8'd0, 8'd0);
        req.pixel_value  = 24'h7F_FFFF;
        req.inv_var      = 16'hFFFF;
        req.pixel_weight = 8'hFF;
        req.is_finite    = 1'b1;
        send_request(req);
        req.is_finite = 1'b0;
        send_request(req);
        // zero inverse variance
        req.is_finite = 1'b1;
        req.inv_var   = '0;
        send_request(req);
        // masked pixel
        req = make_request(ivs_pkg::KIND_STACK, 8'd255, 8'd0);
        req.is_finite = 1'b1;
        req.inv_var   = 16'h0100;
        send_request(req);
        req = make_request(ivs_pkg::KIND_STACK, 8'd255, 8'd255);
        req.pixel_value  = 24'h7F_FFFF;
        req.inv_var      = 16'hFFFF;
        req.pixel_weight = 8'hFF;
        req.is_finite    = 1'b1;
        send_request(req);
        req = make_request(ivs_pkg::KIND_STACK, 8'd0, 8'd255);
        req.pixel_value = 24'h80_0000;
        req.inv_var     = 16'hFFFF;
        req.is_finite   = 1'b1;
        send_request(req);
        send_request(make_request(ivs_pkg::KIND_READ, 8'd0, 8'd255));

        // directed: largest offsets, integer weighting
        set_config(8'd255, 8'd255, 1'b1);
        req = make_request(ivs_pkg::KIND_STACK, 8'd0, 8'd0);
        req.pixel_value  = 24'h80_0000;
        req.inv_var      = '0;
        req.pixel_weight = 8'hFF;
        req.is_finite    = 1'b1;
        send_request(req);
        req.pixel_weight = '0;
        send_request(req);
        req.is_finite = 1'b0;
        send_request(req);
        req = make_request(ivs_pkg::KIND_STACK, 8'd0, 8'd0);
        req.pixel_value  = 24'h7F_FFFF;
        req.pixel_weight = 8'hFF;
        req.is_finite    = 1'b1;
        send_request(req);
        send_request(make_request(ivs_pkg::KIND_STACK, 8'd1, 8'd0));
        send_request(make_request(ivs_pkg::KIND_STACK, 8'd0, 8'd1));
        send_request(make_request(ivs_pkg::KIND_STACK, 8'd255, 8'd255));

        // random phases over several register settings
        send_idle_pct = 25;
        recv_idle_pct = 25;
        set_config(8'd0, 8'd0, 1'b0);
        run_random_phase(230);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'd0, 8'd0, 1'b1);
        run_random_phase(150);
        send_idle_pct = 40;
        recv_idle_pct = 10;
        set_config(8'($urandom), 8'($urandom), 1'b0);
        run_random_phase(180);
        send_idle_pct = 10;
        recv_idle_pct = 40;
        set_config(8'($urandom), 8'($urandom), 1'b1);
        run_random_phase(180);
        send_idle_pct = 25;
        recv_idle_pct = 25;
        set_config(8'd255, 8'd0, 1'b0);
        run_random_phase(120);
        set_config(8'd0, 8'd255, 1'b1);
        run_random_phase(120);
        // closing stretch at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'($urandom), 8'($urandom), 1'($urandom));
        run_random_phase(150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d loads, %0d stacks (%0d past the frame edge) and %0d reads",
                 load_count, stack_count, outside_count, read_count);
        $display("across %0d register settings, both stack modes, offsets at 0 and 255",
                 setting_count);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* inverse_variance_image_stacker_unit.f */
src/ivs_pkg.sv
src/ivs_item_if.sv
src/ivs_result_if.sv
src/ivs_cfg_if.sv
src/ivs_front.sv
src/ivs_queue.sv
src/ivs_back.sv
src/inverse_variance_image_stacker_unit.sv
test/inverse_variance_image_stacker_checker.sv
test/inverse_variance_image_stacker_unit_tb.sv
